// ----- rtl/frlc_pkg.sv -----
`timescale 1ns / 1ps
package frlc_pkg;

  localparam int unsigned MaxItems = 1024;
  localparam int unsigned AddrW    = $clog2(MaxItems);
  localparam int unsigned CountW   = AddrW + 1;

  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_FINISH = 3'd1,
    OP_READ_ID = 3'd2,
    OP_READ_SIZE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_CLR_HIST,
    ST_IDLE,
    ST_LOAD_RD,
    ST_RDID_RD,
    ST_RDID_MAP,
    ST_RDSZ_RD,
    ST_CLR_TALLY,
    ST_TAL_ISSUE,
    ST_TAL_HIST,
    ST_TAL_CNT,
    ST_PFX_ISSUE,
    ST_PFX_WR,
    ST_ASN_ISSUE,
    ST_ASN_HIST,
    ST_ASN_CNT,
    ST_RESP
  } state_e;

endpackage

// ----- rtl/frlc_ram.sv -----
`timescale 1ns / 1ps
module frlc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/frequency_ranked_label_compactor_core.sv -----
`timescale 1ns / 1ps
// frequency ranked label compactor
// input channel (in_valid_i/in_ready_o) carries operation, label and index;
// output channel (out_valid_o/out_ready_i) returns one result per transfer:
// value, group_count and error.
// load: label store write, then histogram read-modify-write unless negative.
// read dense id: label store ram, then rank map ram.
// read size: sizes ram; errors answer without a ram read.
// finish: the tally ram is cleared, the histogram is walked label by label
// to tally group sizes, a prefix pass runs down the tally ram and a second
// walk assigns ranks, paced by the histogram size and single ram read ports.
// clear: one histogram entry zeroed per cycle.
// after reset a clearing pass zeroes the histogram; in_ready_o
// stays low during it. one item is in work at a time; in_ready_o is high only
// when idle. the output register holds a result until taken; a new item may
// be accepted meanwhile, but its result waits until the output is free.
module frequency_ranked_label_compactor_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic signed [10:0] label_i,
  input  logic [9:0]         index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [11:0] value_o,
  output logic [10:0]        group_count_o,
  output logic               error_o
);
  import frlc_pkg::*;

  state_e state_q, state_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [AddrW-1:0] label_q, label_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] acc_q, acc_d;
  logic [CountW-1:0] item_q, item_d;
  logic [CountW-1:0] distinct_q, distinct_d;
  logic ranked_q, ranked_d;
  logic clr_resp_q, clr_resp_d;
  logic signed [11:0] res_val_q, res_val_d;
  logic res_err_q, res_err_d;
  logic out_valid_q, out_valid_d;
  logic signed [11:0] out_val_q, out_val_d;
  logic [10:0] out_cc_q, out_cc_d;
  logic out_err_q, out_err_d;

  logic st_we, hi_we, ta_we, mp_we, sz_we;
  logic [AddrW-1:0] st_waddr, hi_waddr, hi_raddr, ta_waddr, ta_raddr, sz_waddr;
  logic [CountW-1:0] st_wdata, st_rdata, hi_wdata, hi_rdata, ta_wdata, ta_rdata;
  logic [CountW-1:0] sz_rdata;
  logic [AddrW-1:0] mp_rdata;
  logic [AddrW-1:0] hist_dec;
  logic ptr_last;
  logic in_xfer;

  frlc_ram #(.Width(CountW), .Depth(MaxItems)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(index_i), .rdata_o(st_rdata)
  );
  frlc_ram #(.Width(CountW), .Depth(MaxItems)) u_hist (
    .clk_i, .we_i(hi_we), .waddr_i(hi_waddr), .wdata_i(hi_wdata),
    .raddr_i(hi_raddr), .rdata_o(hi_rdata)
  );
  frlc_ram #(.Width(CountW), .Depth(MaxItems)) u_tally (
    .clk_i, .we_i(ta_we), .waddr_i(ta_waddr), .wdata_i(ta_wdata),
    .raddr_i(ta_raddr), .rdata_o(ta_rdata)
  );
  frlc_ram #(.Width(AddrW), .Depth(MaxItems)) u_map (
    .clk_i, .we_i(mp_we), .waddr_i(ptr_q), .wdata_i(ta_rdata[AddrW-1:0]),
    .raddr_i(st_rdata[AddrW-1:0]), .rdata_o(mp_rdata)
  );
  frlc_ram #(.Width(CountW), .Depth(MaxItems)) u_sizes (
    .clk_i, .we_i(sz_we), .waddr_i(sz_waddr), .wdata_i(cnt_q),
    .raddr_i(index_i), .rdata_o(sz_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer = in_valid_i && in_ready_o;
  assign ptr_last = (ptr_q == {AddrW{1'b1}});
  assign hist_dec = AddrW'(hi_rdata - CountW'(1));
  assign sz_waddr = ta_rdata[AddrW-1:0];

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q;
    label_d = label_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    item_d = item_q;
    distinct_d = distinct_q;
    ranked_d = ranked_q;
    clr_resp_d = clr_resp_q;
    res_val_d = res_val_q;
    res_err_d = res_err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d = out_val_q;
    out_cc_d = out_cc_q;
    out_err_d = out_err_q;
    st_we = 1'b0;
    st_waddr = item_q[AddrW-1:0];
    st_wdata = label_i[10] ? {CountW{1'b1}} : CountW'(label_i);
    hi_we = 1'b0;
    hi_waddr = ptr_q;
    hi_wdata = '0;
    hi_raddr = ptr_q;
    ta_we = 1'b0;
    ta_waddr = ptr_q;
    ta_wdata = '0;
    ta_raddr = ptr_q;
    mp_we = 1'b0;
    sz_we = 1'b0;

    unique case (state_q)
      ST_CLR_HIST: begin
        hi_we = 1'b1;
        ptr_d = ptr_q + AddrW'(1);
        if (ptr_last) begin
          state_d = clr_resp_q ? ST_RESP : ST_IDLE;
          clr_resp_d = 1'b0;
        end
      end
      ST_IDLE: begin
        hi_raddr = label_i[AddrW-1:0];
        res_val_d = '0;
        res_err_d = 1'b0;
        label_d = label_i[AddrW-1:0];
        ptr_d = '0;
        if (in_xfer) begin
          state_d = ST_RESP;
          unique case (operation_i)
            OP_LOAD: begin
              if (item_q == CountW'(MaxItems)) begin
                res_err_d = 1'b1;
              end else begin
                st_we = 1'b1;
                item_d = item_q + CountW'(1);
                ranked_d = 1'b0;
                if (!label_i[10]) state_d = ST_LOAD_RD;
              end
            end
            OP_FINISH: state_d = ST_CLR_TALLY;
            OP_READ_ID: begin
              if (!ranked_q || CountW'(index_i) >= item_q) res_err_d = 1'b1;
              else state_d = ST_RDID_RD;
            end
            OP_READ_SIZE: begin
              if (!ranked_q || CountW'(index_i) >= distinct_q) res_err_d = 1'b1;
              else state_d = ST_RDSZ_RD;
            end
            OP_CLEAR: begin
              item_d = '0;
              distinct_d = '0;
              ranked_d = 1'b0;
              clr_resp_d = 1'b1;
              state_d = ST_CLR_HIST;
            end
            default: res_err_d = 1'b1;
          endcase
        end
      end
      ST_LOAD_RD: begin
        hi_we = 1'b1;
        hi_waddr = label_q;
        hi_wdata = hi_rdata + CountW'(1);
        state_d = ST_RESP;
      end
      ST_RDID_RD: begin
        if (st_rdata[CountW-1]) begin
          res_val_d = -12'sd1;
          state_d = ST_RESP;
        end else begin
          state_d = ST_RDID_MAP;
        end
      end
      ST_RDID_MAP: begin
        res_val_d = 12'(mp_rdata);
        state_d = ST_RESP;
      end
      ST_RDSZ_RD: begin
        res_val_d = 12'(sz_rdata);
        state_d = ST_RESP;
      end
      ST_CLR_TALLY: begin
        ta_we = 1'b1;
        ptr_d = ptr_q + AddrW'(1);
        if (ptr_last) state_d = ST_TAL_ISSUE;
      end
      ST_TAL_ISSUE: state_d = ST_TAL_HIST;
      ST_TAL_HIST: begin
        ta_raddr = hist_dec;
        cnt_d = hi_rdata;
        if (hi_rdata != '0) begin
          state_d = ST_TAL_CNT;
        end else begin
          ptr_d = ptr_last ? {AddrW{1'b1}} : ptr_q + AddrW'(1);
          state_d = ptr_last ? ST_PFX_ISSUE : ST_TAL_ISSUE;
          acc_d = '0;
        end
      end
      ST_TAL_CNT: begin
        ta_we = 1'b1;
        ta_waddr = AddrW'(cnt_q - CountW'(1));
        ta_wdata = ta_rdata + CountW'(1);
        ptr_d = ptr_last ? {AddrW{1'b1}} : ptr_q + AddrW'(1);
        state_d = ptr_last ? ST_PFX_ISSUE : ST_TAL_ISSUE;
        acc_d = '0;
      end
      ST_PFX_ISSUE: state_d = ST_PFX_WR;
      ST_PFX_WR: begin
        ta_we = 1'b1;
        ta_wdata = acc_q;
        acc_d = acc_q + ta_rdata;
        ptr_d = ptr_q - AddrW'(1);
        if (ptr_q == '0) begin
          ptr_d = '0;
          distinct_d = acc_q + ta_rdata;
          state_d = ST_ASN_ISSUE;
        end else begin
          state_d = ST_PFX_ISSUE;
        end
      end
      ST_ASN_ISSUE: state_d = ST_ASN_HIST;
      ST_ASN_HIST: begin
        ta_raddr = hist_dec;
        cnt_d = hi_rdata;
        if (hi_rdata != '0) begin
          state_d = ST_ASN_CNT;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
          if (ptr_last) begin
            ranked_d = 1'b1;
            state_d = ST_RESP;
          end else begin
            state_d = ST_ASN_ISSUE;
          end
        end
      end
      ST_ASN_CNT: begin
        ta_we = 1'b1;
        ta_waddr = AddrW'(cnt_q - CountW'(1));
        ta_wdata = ta_rdata + CountW'(1);
        mp_we = 1'b1;
        sz_we = 1'b1;
        ptr_d = ptr_q + AddrW'(1);
        if (ptr_last) begin
          ranked_d = 1'b1;
          state_d = ST_RESP;
        end else begin
          state_d = ST_ASN_ISSUE;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_val_d = res_val_q;
          out_err_d = res_err_q;
          out_cc_d = ranked_q ? distinct_q : '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR_HIST;
      ptr_q <= '0;
      item_q <= '0;
      distinct_q <= '0;
      ranked_q <= 1'b0;
      clr_resp_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q <= ptr_d;
      item_q <= item_d;
      distinct_q <= distinct_d;
      ranked_q <= ranked_d;
      clr_resp_q <= clr_resp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    label_q <= label_d;
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    res_val_q <= res_val_d;
    res_err_q <= res_err_d;
    out_val_q <= out_val_d;
    out_cc_q <= out_cc_d;
    out_err_q <= out_err_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o = out_val_q;
  assign group_count_o = out_cc_q;
  assign error_o = out_err_q;

endmodule
